// ----- rtl/itad_pkg.sv -----
`default_nettype none

package itad_pkg;

  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

  localparam logic [BASE_W-1:0]  BASE_RESET  = 6'd10;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd5;
  localparam logic [BASE_W-1:0]  BASE_MIN    = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX    = 6'd36;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_GAP      = 7'd7;
  localparam logic [DIGIT_W-1:0] LARGEST_DECIMAL = 6'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] gap;
    gap = (d > LARGEST_DECIMAL) ? LETTER_GAP : '0;
    return ASCII_ZERO + {1'b0, d} + gap;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itad_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module itad_div #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [VALUE_BITS-1:0]         dividend_i,
  input  wire logic [itad_pkg::BASE_W-1:0]   divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [VALUE_BITS-1:0]              quot_o,
  output logic [itad_pkg::DIGIT_W-1:0]       rem_o
);
  import itad_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [BASE_W-1:0]     dvs_q, dvs_d;
  logic [DIGIT_W:0]      rem_sh;
  logic                  ge;

  assign rem_sh = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits back in DIGIT_W bits
      rem_d = ge ? DIGIT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIGIT_W-1:0];
      quo_d = {quo_q[VALUE_BITS-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_digits_top.sv -----
`default_nettype none

// Each word's digits come from the one shared bit-serial divider, one digit per division.
// Chars go out one per cycle while the sink is ready; the next word is taken in the cycle
// after the last char is loaded into the output register.
// Reset: radix 10, width 5, idle, no output.
module integer_to_ascii_digits_top #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned MAX_DIGITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [itad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [itad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [VALUE_BITS-1:0]           number_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [itad_pkg::CHAR_W-1:0]          digit_char_o,
  output logic                                 last_digit_o
);
  import itad_pkg::*;

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [BASE_W-1:0]  base_q;
  logic [COUNT_W-1:0] count_q;
  logic [BASE_W-1:0]  base_eff;
  logic [5:0]         count_eff;
  logic [IDX_W-1:0]   last_idx;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];

  logic                  div_start, div_busy, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic              in_acc, out_load, dig_we;
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_BASE) begin
        base_q <= cfg_data_i[BASE_W-1:0];
      end else if (cfg_idx_i == REG_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (base_q < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (base_q > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = base_q;
    end
    priority if (count_q == '0) begin
      count_eff = 6'd1;
    end else if ({1'b0, count_q} > 6'(MAX_DIGITS)) begin
      count_eff = 6'(MAX_DIGITS);
    end else begin
      count_eff = {1'b0, count_q};
    end
  end

  assign last_idx = IDX_W'(count_eff - 6'd1);

  itad_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (base_eff),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // sequencer: k counts digits up while dividing, then back down while emitting
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    div_start    = 1'b0;
    div_dividend = number_in_i;
    dig_we       = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          div_start = 1'b1;
          k_d       = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        div_dividend = div_quot;
        if (div_done) begin
          dig_we = 1'b1;
          if (k_q == last_idx) begin
            state_d = ST_EMIT;
          end else begin
            k_d       = k_q + IDX_W'(1);
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (k_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[k_q] <= div_rem;
    end
  end

  // output register, decouples the sink from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      char_q <= digit_to_ascii(digits_q[k_q]);
      last_q <= (k_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("word accepted while divider busy");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                    (digit_char_o >= 7'd65 && digit_char_o <= 7'd90))
    else $error("char outside digit range");
`endif

endmodule

`default_nettype wire
